// File: rtl/mt64_state_step_and_combine_core_assert.svh
// assertion macros shared by the checker of the mt64 state core
// no dependencies; take in by `include with the bare file name
`ifndef MT64_STATE_STEP_AND_COMBINE_CORE_ASSERT_SVH
`define MT64_STATE_STEP_AND_COMBINE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MT64SC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mt64 state core: property failed");

// next-cycle implication, disabled during reset
`define MT64SC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mt64 state core: property failed");

`endif

// File: rtl/mt64sc_pkg.sv
// shared widths, operation codes and twist constants of the mt64 state core
// no dependencies
package mt64sc_pkg;

    localparam int OP_W   = 3;
    localparam int POS_W  = 9;
    localparam int WORD_W = 64;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 3'd0,
        OP_TWIST  = 3'd1,
        OP_XOR    = 3'd2,
        OP_READ   = 3'd3,
        OP_SETPOS = 3'd4
    } op_t;

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
    localparam logic [WORD_W-1:0] UPPER_MASK   = 64'hFFFF_FFFF_8000_0000;
    localparam logic [WORD_W-1:0] LOWER_MASK   = 64'h0000_0000_7FFF_FFFF;

endpackage

// File: rtl/mt64sc_req_if.sv
// request channel of the mt64 state core: valid/ready plus operation fields
// depends on mt64sc_pkg
interface mt64sc_req_if;
    logic                          valid;
    logic                          ready;
    logic [mt64sc_pkg::OP_W-1:0]   operation;
    logic [mt64sc_pkg::POS_W-1:0]  word_offset;
    logic [mt64sc_pkg::WORD_W-1:0] data_word;

    modport source (output valid, output operation, output word_offset,
                    output data_word, input ready);
    modport sink   (input valid, input operation, input word_offset,
                    input data_word, output ready);
endinterface

// File: rtl/mt64sc_rsp_if.sv
// response channel of the mt64 state core: valid/ready plus result fields
// depends on mt64sc_pkg
interface mt64sc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mt64sc_pkg::WORD_W-1:0] read_data;
    logic [mt64sc_pkg::POS_W-1:0]  position;

    modport source (output valid, output read_data, output position, input ready);
    modport sink   (input valid, input read_data, input position, output ready);
endinterface

// File: rtl/mt64_state_step_and_combine_core.sv
// top level of the mt64 state core: word store, twist step and jump-ahead xor
// depends on mt64sc_pkg, mt64sc_req_if, mt64sc_rsp_if, mt64sc_ram
//
// usage
//   req carries one request (operation, word_offset, data_word); it is taken
//   when req.valid and req.ready are both high. rsp returns exactly one
//   result (read_data, position) per request, in request order.
//   read_data is the stored word for a read and zero for every other code;
//   position is the current position after the request.
// sequencing
//   requests are worked one at a time by a small sequencer around a
//   two-read, one-write word ram. after acceptance, write and set position
//   (and unused codes) pass exec and finish; read and xor accumulate pass
//   exec, read and finish; a twist passes exec, read, twist and finish. the
//   next request is taken back in idle; the twist is the longest
//   because its middle word is read after the first two.
// reset
//   rst_n clears control state, then a clearing pass writes zero to every
//   word, one per cycle, with req.ready low throughout.
// stalls
//   the output register holds a result until rsp.ready; the next request is
//   still taken and worked, and only its final result step waits for room.
module mt64_state_step_and_combine_core #(
    parameter int STATE_WORDS     = 312,
    parameter int MIDDLE_DISTANCE = 156
) (
    input  logic          clk,
    input  logic          rst_n,
    mt64sc_req_if.sink    req,
    mt64sc_rsp_if.source  rsp
);

    import mt64sc_pkg::*;

    localparam int IDX_W   = $clog2(STATE_WORDS);
    localparam int WIDE_W  = POS_W + 8;
    localparam int MID_OFF = MIDDLE_DISTANCE % STATE_WORDS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_TWIST,
        ST_FINISH
    } state_t;

    // remainder by the store size: restoring reduction over eight shifted
    // copies of the constant divisor, enough for any 9-bit value
    function automatic logic [POS_W-1:0] mod_words(input logic [POS_W-1:0] v);
        logic [WIDE_W-1:0] r;
        r = WIDE_W'(v);
        for (int k = 7; k >= 0; k--)
        begin
            if (r >= (WIDE_W'(STATE_WORDS) << k))
            begin
                r = r - (WIDE_W'(STATE_WORDS) << k);
            end
        end
        return r[POS_W-1:0];
    endfunction

    // add two in-range indexes and wrap once
    function automatic logic [POS_W-1:0] add_wrap(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (POS_W+1)'(STATE_WORDS))
        begin
            s = s - (POS_W+1)'(STATE_WORDS);
        end
        return s[POS_W-1:0];
    endfunction

    state_t              state_reg,   state_next;
    logic [IDX_W-1:0]    clr_cnt_reg, clr_cnt_next;
    op_t                 op_reg,      op_next;
    logic [POS_W-1:0]    off_reg,     off_next;
    logic [POS_W-1:0]    offmod_reg,  offmod_next;
    logic [WORD_W-1:0]   data_reg,    data_next;
    logic [POS_W-1:0]    tgt_reg,     tgt_next;
    logic [POS_W-1:0]    pos_reg,     pos_next;
    logic [WORD_W-1:0]   y_reg,       y_next;
    logic [WORD_W-1:0]   rd_reg,      rd_next;
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_rd_reg,  out_rd_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]    ram_raddr_a;
    logic [IDX_W-1:0]    ram_raddr_b;
    logic [WORD_W-1:0]   ram_rdata_a;
    logic [WORD_W-1:0]   ram_rdata_b;

    logic [POS_W-1:0]    tgt_w;
    logic [POS_W-1:0]    pos_inc_w;
    logic [POS_W-1:0]    mid_w;

    mt64sc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // word addresses around the current position
    assign tgt_w     = add_wrap(pos_reg, offmod_reg);
    assign pos_inc_w = add_wrap(pos_reg, POS_W'(1));
    assign mid_w     = add_wrap(pos_reg, POS_W'(MID_OFF));

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_rd_reg;
    assign rsp.position  = out_pos_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        op_next        = op_reg;
        off_next       = off_reg;
        offmod_next    = offmod_reg;
        data_next      = data_reg;
        tgt_next       = tgt_reg;
        pos_next       = pos_reg;
        y_next         = y_reg;
        rd_next        = rd_reg;
        out_valid_next = out_valid_reg;
        out_rd_next    = out_rd_reg;
        out_pos_next   = out_pos_reg;

        ram_we      = 1'b0;
        ram_waddr   = tgt_reg[IDX_W-1:0];
        ram_wdata   = '0;
        ram_raddr_a = tgt_w[IDX_W-1:0];
        ram_raddr_b = pos_inc_w[IDX_W-1:0];

        // result taken by the receiver
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // zero one word per cycle after reset
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == IDX_W'(STATE_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = op_t'(req.operation);
                    off_next    = req.word_offset;
                    offmod_next = mod_words(req.word_offset);
                    data_next   = req.data_word;
                    rd_next     = '0;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                tgt_next = tgt_w;
                case (op_reg)
                    OP_WRITE:
                    begin
                        // absolute index beyond the store is dropped
                        if (off_reg < POS_W'(STATE_WORDS))
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = off_reg[IDX_W-1:0];
                            ram_wdata = data_reg;
                        end
                        state_next = ST_FINISH;
                    end
                    OP_SETPOS:
                    begin
                        if (off_reg < POS_W'(STATE_WORDS))
                        begin
                            pos_next = off_reg;
                        end
                        state_next = ST_FINISH;
                    end
                    OP_TWIST:
                    begin
                        // words at p and p+1 on the two read ports
                        ram_raddr_a = pos_reg[IDX_W-1:0];
                        state_next  = ST_READ;
                    end
                    OP_XOR, OP_READ:
                    begin
                        state_next = ST_READ;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_READ:
            begin
                case (op_reg)
                    OP_TWIST:
                    begin
                        y_next      = (ram_rdata_a & UPPER_MASK) | (ram_rdata_b & LOWER_MASK);
                        ram_raddr_a = mid_w[IDX_W-1:0];
                        state_next  = ST_TWIST;
                    end
                    OP_XOR:
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = tgt_reg[IDX_W-1:0];
                        ram_wdata  = ram_rdata_a ^ data_reg;
                        state_next = ST_FINISH;
                    end
                    OP_READ:
                    begin
                        rd_next    = ram_rdata_a;
                        state_next = ST_FINISH;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_TWIST:
            begin
                // middle word arrives now; write back at p and advance
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[IDX_W-1:0];
                ram_wdata  = ram_rdata_a ^ (y_reg >> 1) ^ (y_reg[0] ? TWIST_MATRIX : '0);
                pos_next   = pos_inc_w;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait here only while the output register is still full
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = rd_reg;
                    out_pos_next   = pos_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            op_reg        <= OP_WRITE;
            off_reg       <= '0;
            offmod_reg    <= '0;
            data_reg      <= '0;
            tgt_reg       <= '0;
            pos_reg       <= '0;
            y_reg         <= '0;
            rd_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_rd_reg    <= '0;
            out_pos_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            op_reg        <= op_next;
            off_reg       <= off_next;
            offmod_reg    <= offmod_next;
            data_reg      <= data_next;
            tgt_reg       <= tgt_next;
            pos_reg       <= pos_next;
            y_reg         <= y_next;
            rd_reg        <= rd_next;
            out_valid_reg <= out_valid_next;
            out_rd_reg    <= out_rd_next;
            out_pos_reg   <= out_pos_next;
        end
    end

endmodule

// File: rtl/mt64sc_ram.sv
// generic ram: one write port, two read ports with registered read data
// no dependencies
module mt64sc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 312
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: rtl/mt64sc_chk.sv
// port-level checker of the mt64 state core, bound to the top level
// depends on mt64sc_pkg and mt64_state_step_and_combine_core_assert.svh
`include "mt64_state_step_and_combine_core_assert.svh"

module mt64sc_chk #(
    parameter int STATE_WORDS = 312
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [mt64sc_pkg::WORD_W-1:0] rsp_read_data,
    input logic [mt64sc_pkg::POS_W-1:0]  rsp_position
);

    import mt64sc_pkg::*;

    // a stalled result stays offered and unchanged
    `MT64SC_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `MT64SC_ASSERT_NXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_read_data) && $stable(rsp_position))

    // reported position always lies inside the store
    `MT64SC_ASSERT_IMP(a_pos_range, clk, rst_n, rsp_valid, rsp_position < POS_W'(STATE_WORDS))

    // clearing pass keeps requests out right after reset
    `MT64SC_ASSERT_IMP(a_clear_busy, clk, rst_n, !$past(rst_n), !req_ready)

    // one request at a time: no request taken in the cycle after one
    `MT64SC_ASSERT_NXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready)

endmodule

bind mt64_state_step_and_combine_core mt64sc_chk #(
    .STATE_WORDS (STATE_WORDS)
) u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_read_data (rsp.read_data),
    .rsp_position  (rsp.position)
);

// File: bench/testbench.sv
// self-checking bench for mt64_state_step_and_combine_core: random requests with idle gaps
// carries its own model of the word store and position and checks every result in order
// depends on mt64sc_pkg, mt64sc_req_if, mt64sc_rsp_if and the core itself
module testbench;

    import mt64sc_pkg::*;

    localparam int STATE_WORDS     = 312;
    localparam int MIDDLE_DISTANCE = 156;

    // codes the core must treat as no-ops
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    localparam int MAX_PRINTED  = 100;
    localparam int PRESSURE_RUN = 40;
    localparam int HOLD_CYCLES  = 200;

    typedef struct {
        logic [WORD_W-1:0] read_data;
        logic [POS_W-1:0]  position;
    } result_t;

    // mirror of the core: word store, position and the results still owed
    class mt_state_tracker;
        logic [WORD_W-1:0] words [STATE_WORDS];
        logic [POS_W-1:0]  pos;
        result_t           owed_results [$];
        int                errors;

        function new();
            foreach (words[i])
                words[i] = '0;
            pos    = '0;
            errors = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        task report(input string what);
            if (errors < MAX_PRINTED)
                $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        // one accepted request: update the mirror and queue the result it owes
        function void note_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] off,
                                   input logic [WORD_W-1:0] data);
            int                cur;
            int                nxt;
            int                mid;
            int                tgt;
            logic [WORD_W-1:0] y;
            logic [WORD_W-1:0] v;
            result_t           res;

            cur = int'(pos);
            tgt = (cur + int'(off)) % STATE_WORDS;
            res.read_data = '0;
            case (op)
                OP_WRITE:
                begin
                    if (int'(off) < STATE_WORDS)
                        words[off] = data;
                end
                OP_TWIST:
                begin
                    nxt = (cur + 1) % STATE_WORDS;
                    mid = (cur + MIDDLE_DISTANCE) % STATE_WORDS;
                    y   = (words[cur] & UPPER_MASK) | (words[nxt] & LOWER_MASK);
                    v   = words[mid] ^ (y >> 1);
                    if (y[0])
                        v = v ^ TWIST_MATRIX;
                    words[cur] = v;
                    pos        = POS_W'(nxt);
                end
                OP_XOR:
                    words[tgt] = words[tgt] ^ data;
                OP_READ:
                    res.read_data = words[tgt];
                OP_SETPOS:
                begin
                    if (int'(off) < STATE_WORDS)
                        pos = off;
                end
                default:
                    ;
            endcase
            res.position = pos;
            owed_results.push_back(res);
        endfunction

        task check_result(input logic [WORD_W-1:0] read_data, input logic [POS_W-1:0] position);
            result_t want;
            if (owed_results.size() == 0)
            begin
                report($sformatf("result %h/%0d with no request outstanding", read_data, position));
                return;
            end
            want = owed_results.pop_front();
            if (read_data !== want.read_data)
                report($sformatf("read_data %h, want %h", read_data, want.read_data));
            if (position !== want.position)
                report($sformatf("position %0d, want %0d", position, want.position));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mt64sc_req_if req_ch ();
    mt64sc_rsp_if rsp_ch ();

    mt64_state_step_and_combine_core #(
        .STATE_WORDS     (STATE_WORDS),
        .MIDDLE_DISTANCE (MIDDLE_DISTANCE)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    mt_state_tracker tracker = new();

    // idling controls shared between the request driver and the result taker
    bit tx_random  = 1'b1;
    bit rx_random  = 1'b1;
    int rx_hold    = 0;
    int stall_left = 0;

    always #10 clk = ~clk;

    // every input known from time zero
    initial
    begin
        req_ch.valid       = 1'b0;
        req_ch.operation   = '0;
        req_ch.word_offset = '0;
        req_ch.data_word   = '0;
        rsp_ch.ready       = 1'b0;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // twists dominate so the position walks; unused codes show up rarely
    function automatic logic [OP_W-1:0] pick_operation();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return OP_WRITE;
        if (r < 45)
            return OP_TWIST;
        if (r < 60)
            return OP_XOR;
        if (r < 80)
            return OP_READ;
        if (r < 92)
            return OP_SETPOS;
        return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    // set position leans toward the last words so twists cross the wrap often
    function automatic logic [POS_W-1:0] pick_offset(input logic [OP_W-1:0] op);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return POS_W'($urandom_range(STATE_WORDS, 511));
        if (op == OP_SETPOS && r < 60)
            return POS_W'($urandom_range(STATE_WORDS - 12, STATE_WORDS - 1));
        return POS_W'($urandom_range(0, STATE_WORDS - 1));
    endfunction

    // enter and leave at a falling edge; valid stays high into a back-to-back request
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] off,
                                input logic [WORD_W-1:0] data);
        int n;
        req_ch.valid       = 1'b1;
        req_ch.operation   = op;
        req_ch.word_offset = off;
        req_ch.data_word   = data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tracker.note_request(op, off, data);
        @(negedge clk);
        n = tx_random ? gap_len() : 0;
        if (n > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_random(input int count);
        logic [OP_W-1:0] op;
        repeat (count)
        begin
            op = pick_operation();
            send_request(op, pick_offset(op), random_word());
        end
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
    endtask

    // result side: ready moves at the falling edge, results are taken at the rising edge
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                // long hold-off so the core backs up into its request side
                rsp_ch.ready = 1'b0;
                rx_hold--;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                if (rx_random)
                    stall_left = gap_len();
            end
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_result(rsp_ch.read_data, rsp_ch.position);
        end
    end

    initial
    begin
        // hold reset, then release it; the core then clears its store before taking requests
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: fresh store reads as zero at both ends
        send_request(OP_READ, 9'd0, '1);
        send_request(OP_READ, 9'd311, '0);
        // writes at the first, second, middle and last words
        send_request(OP_WRITE, 9'd0, '1);
        send_request(OP_WRITE, 9'd311, 64'h8000_0000_0000_0001);
        send_request(OP_WRITE, 9'd1, 64'h0000_0000_7FFF_FFFF);
        send_request(OP_WRITE, 9'd156, 64'hAAAA_AAAA_AAAA_AAAA);
        // write index past the store must be dropped
        send_request(OP_WRITE, 9'd312, 64'h5555_5555_5555_5555);
        send_request(OP_WRITE, 9'd511, '1);
        // twist with the low bit of y set, so the matrix is folded in
        send_request(OP_TWIST, 9'd0, '0);
        // twist of the last word reads word zero and wraps the position
        send_request(OP_SETPOS, 9'd311, '0);
        send_request(OP_TWIST, 9'd511, '1);
        send_request(OP_READ, 9'd0, '0);
        send_request(OP_READ, 9'd311, '0);
        // position out of range leaves it where it is
        send_request(OP_SETPOS, 9'd312, '0);
        send_request(OP_SETPOS, 9'd511, '1);
        // accumulate and read with offsets that wrap past the end
        send_request(OP_XOR, 9'd311, 64'h0123_4567_89AB_CDEF);
        send_request(OP_XOR, 9'd511, '1);
        send_request(OP_READ, 9'd511, '0);
        send_request(OP_READ, 9'd311, '0);
        // unused codes change nothing
        send_request(OP_UNUSED_LO, 9'd5, '1);
        send_request(OP_UNUSED_LO + 3'd1, 9'd511, 64'hDEAD_BEEF_0000_0001);
        send_request(OP_UNUSED_HI, 9'd0, '1);
        // twist with both neighbors zero: low bit of y clear
        send_request(OP_SETPOS, 9'd200, '0);
        send_request(OP_TWIST, 9'd0, '0);
        send_request(OP_READ, 9'd511, '0);

        // random with gaps on both sides
        send_random(400);

        // receiver holds off while requests keep coming back to back
        tx_random = 1'b0;
        rx_hold   = HOLD_CYCLES;
        send_random(PRESSURE_RUN);
        tx_random = 1'b1;

        // sender pauses until every result is back
        wait_drained();

        // stretch with no idling anywhere
        tx_random  = 1'b0;
        rx_random  = 1'b0;
        send_random(350);
        tx_random  = 1'b1;
        rx_random  = 1'b1;

        send_random(460);

        wait_drained();
        repeat (10) @(negedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
